### hw/rtl/speck128_256_block_encrypt_macros.svh
// Assertion macros shared by the checker of the Speck128/256 encryption engine.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SPECK128_256_BLOCK_ENCRYPT_MACROS_SVH
`define SPECK128_256_BLOCK_ENCRYPT_MACROS_SVH

// An antecedent that holds implies the consequent in the same cycle.
`define SPK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("speck engine check failed");

// An antecedent that holds implies the consequent later, after the delay given as n.
`define SPK_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("speck engine latency check failed");

// A condition that must never be seen outside reset.
`define SPK_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("speck engine forbidden condition seen");

`endif

### hw/rtl/spk_pkg.sv
// Shared types, constants and rotate helpers for the Speck128/256 engine.
// No dependencies; imported by the round cell, the top level and the checker.
package spk_pkg;

	localparam int CELLS = 34;            // one cell per cipher round
	localparam int LATENCY = CELLS;       // one register per cell between accepted word and result strobe
	localparam int WORD_W = 64;
	localparam int RND_W = 6;
	localparam int ADDR_W = 6;

	// Register indexes, taken from paddr[5:3].
	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_ROUNDS = 3'd4;

	localparam logic [RND_W-1:0] ROUNDS_RESET = 6'd34;

	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} data_t;

	typedef struct packed {
		logic [WORD_W-1:0] k;
		logic [WORD_W-1:0] l0;
		logic [WORD_W-1:0] l1;
		logic [WORD_W-1:0] l2;
	} key_t;

	function automatic logic [WORD_W-1:0] rotr8(input logic [WORD_W-1:0] v);
		return {v[7:0], v[WORD_W-1:8]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl3(input logic [WORD_W-1:0] v);
		return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
	endfunction

endpackage

### hw/rtl/spk_cell.sv
// One Speck round cell: applies a round to the passing word and steps the key schedule.
// Depends on spk_pkg for the data and key structs and the rotate helpers.
module spk_cell import spk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [RND_W-1:0] idx,
	input  logic [RND_W-1:0] rounds,
	input  data_t            data_i,
	input  key_t             key_i,
	output data_t            data_o,
	output key_t             key_o
);

	logic              apply;
	logic [WORD_W-1:0] x_rnd;
	logic [WORD_W-1:0] y_rnd;
	logic [WORD_W-1:0] mid;
	logic              valid_q;
	logic [WORD_W-1:0] x_s1;
	logic [WORD_W-1:0] y_s1;
	key_t              key_s1;

	// Rounds beyond the configured count leave the word untouched; a count above the
	// number of cells simply enables every cell.
	assign apply = (rounds > idx);

	always_comb begin
		x_rnd = (rotr8(data_i.x) + data_i.y) ^ key_i.k;
		y_rnd = rotl3(data_i.y) ^ x_rnd;
		mid   = (rotr8(key_i.l0) + key_i.k) ^ {{(WORD_W-RND_W){1'b0}}, idx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= data_i.valid;
		end
	end

	// The key state runs freely alongside the data, so each word meets the round key
	// that was launched from the key registers in the same cycle as the word itself.
	always_ff @(posedge clk) begin
		x_s1      <= apply ? x_rnd : data_i.x;
		y_s1      <= apply ? y_rnd : data_i.y;
		key_s1.k  <= mid ^ rotl3(key_i.k);
		key_s1.l0 <= key_i.l1;
		key_s1.l1 <= key_i.l2;
		key_s1.l2 <= mid;
	end

	assign data_o = '{valid: valid_q, x: x_s1, y: y_s1};
	assign key_o  = key_s1;

endmodule

### hw/rtl/speck128_256_block_encrypt.sv
// Top level of the Speck128/256 encryption engine: register port and chain of round cells.
// Depends on spk_pkg and spk_cell.
//
//  channel   handshake          payload
//  input     start, busy        x_in, y_in
//  result    done (strobe)      x_out, y_out
//  config    APB psel/penable   paddr, pwdata, prdata
//
// A word is accepted in every cycle; busy is never raised.
// Each result appears at the end of the chain of 34 round cells, each of which registers the word once.
// Results leave in order of acceptance, one cycle each, and cannot be held off.
// Reset clears the register file and all valid flags in the chain; key words reset to zero
// and the round count to 34.
module speck128_256_block_encrypt import spk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [WORD_W-1:0] x_in,
	input  logic [WORD_W-1:0] y_in,
	output logic              done,
	output logic [WORD_W-1:0] x_out,
	output logic [WORD_W-1:0] y_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0] pwdata,
	output logic [WORD_W-1:0] prdata,
	output logic              pready
);

	logic [WORD_W-1:0] key0_q;
	logic [WORD_W-1:0] key1_q;
	logic [WORD_W-1:0] key2_q;
	logic [WORD_W-1:0] key3_q;
	logic [RND_W-1:0]  rounds_q;
	logic              cfg_wr;
	data_t             chain_d [CELLS+1];
	key_t              chain_k [CELLS+1];

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q   <= '0;
			key1_q   <= '0;
			key2_q   <= '0;
			key3_q   <= '0;
			rounds_q <= ROUNDS_RESET;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_KEY0:   key0_q   <= pwdata;
				REG_KEY1:   key1_q   <= pwdata;
				REG_KEY2:   key2_q   <= pwdata;
				REG_KEY3:   key3_q   <= pwdata;
				REG_ROUNDS: rounds_q <= pwdata[RND_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_KEY0:   prdata = key0_q;
			REG_KEY1:   prdata = key1_q;
			REG_KEY2:   prdata = key2_q;
			REG_KEY3:   prdata = key3_q;
			REG_ROUNDS: prdata = {{(WORD_W-RND_W){1'b0}}, rounds_q};
			default:    prdata = '0;
		endcase
	end

	assign chain_d[0] = '{valid: start & ~busy, x: x_in, y: y_in};
	assign chain_k[0] = '{k: key0_q, l0: key1_q, l1: key2_q, l2: key3_q};

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		spk_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (RND_W'(g)),
			.rounds (rounds_q),
			.data_i (chain_d[g]),
			.key_i  (chain_k[g]),
			.data_o (chain_d[g+1]),
			.key_o  (chain_k[g+1])
		);
	end

	assign done  = chain_d[CELLS].valid;
	assign x_out = chain_d[CELLS].x;
	assign y_out = chain_d[CELLS].y;

endmodule

### hw/rtl/spk_checker.sv
// Port-level checker for the Speck128/256 engine, bound to the top level.
// Depends on spk_pkg and the assertion macros header.
`include "speck128_256_block_encrypt_macros.svh"

module spk_checker import spk_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic pready
);

	// Every accepted word must come out as a result strobe at the end of the chain.
	`SPK_ASSERT_DELAY(a_word_out, clk, arst_n, start && !busy, LATENCY, done)

	// A result strobe without a matching word accepted at the head of the chain is invented.
	`SPK_ASSERT_IMPL(a_no_phantom, clk, arst_n, done, $past(start && !busy, LATENCY))

	// The engine never stalls its input side.
	`SPK_ASSERT_NEVER(a_never_busy, clk, arst_n, busy)

	// The register port completes every access in its access cycle.
	`SPK_ASSERT_NEVER(a_pready_low, clk, arst_n, !pready)

endmodule

bind speck128_256_block_encrypt spk_checker u_spk_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.pready (pready)
);

### bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the Speck128/256 encryption engine; a class tracks expected ciphertext.
// Depends on spk_pkg and on speck128_256_block_encrypt; reads no files.
module tb_top;
	import spk_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int ROUNDS_LIMIT = 34;
	localparam int GAP_MAX = 18;
	localparam int RANDOM_WORDS = 1500;
	localparam int REPORT_LIMIT = 10;
	localparam logic [2:0] REG_LAST = 3'd7;

	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} block_t;

	class speck_tracker;
		logic [WORD_W-1:0] key_word [4];
		logic [RND_W-1:0]  round_cfg;
		block_t            ciphertext_q [$];
		int                mismatches;

		function new();
			for (int i = 0; i < 4; i++)
				key_word[i] = '0;
			round_cfg = ROUNDS_RESET;
			mismatches = 0;
		endfunction

		function void write_register(logic [2:0] idx, logic [WORD_W-1:0] value);
			case (idx)
				REG_KEY0: key_word[0] = value;
				REG_KEY1: key_word[1] = value;
				REG_KEY2: key_word[2] = value;
				REG_KEY3: key_word[3] = value;
				REG_ROUNDS: round_cfg = value[RND_W-1:0];
				default: ;
			endcase
		endfunction

		static function logic [WORD_W-1:0] ror8(logic [WORD_W-1:0] v);
			return (v >> 8) | (v << (WORD_W - 8));
		endfunction

		static function logic [WORD_W-1:0] rol3(logic [WORD_W-1:0] v);
			return (v << 3) | (v >> (WORD_W - 3));
		endfunction

		function block_t encrypt_block(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y);
			logic [WORD_W-1:0] k, l0, l1, l2, mid;
			int                n;
			block_t            res;
			k = key_word[0];
			l0 = key_word[1];
			l1 = key_word[2];
			l2 = key_word[3];
			// Counts beyond the number of round cells saturate.
			n = (int'(round_cfg) > ROUNDS_LIMIT) ? ROUNDS_LIMIT : int'(round_cfg);
			for (int i = 0; i < n; i++) begin
				x = (ror8(x) + y) ^ k;
				y = rol3(y) ^ x;
				mid = (ror8(l0) + k) ^ WORD_W'(i);
				k = mid ^ rol3(k);
				l0 = l1;
				l1 = l2;
				l2 = mid;
			end
			res.x = x;
			res.y = y;
			return res;
		endfunction

		function void note_plaintext(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y);
			ciphertext_q.push_back(encrypt_block(x, y));
		endfunction

		function void check_ciphertext(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y);
			block_t want;
			if (ciphertext_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result word x=%h y=%h", x, y);
				return;
			end
			want = ciphertext_q.pop_front();
			if (x !== want.x || y !== want.y) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("ciphertext mismatch: x exp %h got %h, y exp %h got %h",
						want.x, x, want.y, y);
			end
		endfunction

		function int outstanding();
			return ciphertext_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [WORD_W-1:0] x_in;
	logic [WORD_W-1:0] y_in;
	logic              done;
	logic [WORD_W-1:0] x_out;
	logic [WORD_W-1:0] y_out;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [WORD_W-1:0] pwdata;
	logic [WORD_W-1:0] prdata;
	logic              pready;

	speck_tracker tracker = new();

	speck128_256_block_encrypt u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.x_in    (x_in),
		.y_in    (y_in),
		.done    (done),
		.x_out   (x_out),
		.y_out   (y_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	// Results cannot be held off, so every strobe is taken at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			tracker.check_ciphertext(x_out, y_out);
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Biased towards the extremes so that carries and rotations see edge patterns.
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			3: return ~(WORD_W'(1) << $urandom_range(0, WORD_W - 1));
			default: return rand_word();
		endcase
	endfunction

	function automatic int pick_gap(int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, GAP_MAX);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, GAP_MAX) : 0;
		endcase
	endfunction

	// Entered and left at a falling edge; start stays high so that back-to-back words flow.
	task automatic send_block(input logic [WORD_W-1:0] xv, input logic [WORD_W-1:0] yv,
			input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		x_in <= xv;
		y_in <= yv;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_plaintext(xv, yv);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(negedge clk);
		while (tracker.outstanding() != 0)
			@(negedge clk);
	endtask

	// The port is left idle after each write, so back-to-back writes
	// never drive the handshake twice at the same falling edge.
	task automatic write_reg(input logic [2:0] idx, input logic [WORD_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		tracker.write_register(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
			input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
			input logic [WORD_W-1:0] rounds);
		wait_idle();
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_ROUNDS, rounds);
	endtask

	initial begin
		logic [WORD_W-1:0] rounds_word;
		int                sent;
		int                batch;
		int                mode;

		arst_n = 1'b0;
		start = 1'b0;
		x_in = '0;
		y_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset key (all zero) with the full round count.
		send_block('0, '0, 0);
		send_block('1, '1, 0);
		send_block('1, '0, 0);
		send_block('0, '1, 0);
		send_block({WORD_W/2{2'b01}}, {WORD_W/2{2'b10}}, 0);
		send_block(WORD_W'(1), {1'b1, {(WORD_W-1){1'b0}}}, 0);

		// Published Speck128/256 test vector.
		load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
			64'h1f1e1d1c1b1a1918, WORD_W'(ROUNDS_RESET));
		send_block(64'h65736f6874206e49, 64'h202e72656e6f6f70, 0);
		send_block('1, '0, 3);
		send_block('0, '1, 0);

		// With no rounds the block passes straight through.
		wait_idle();
		write_reg(REG_ROUNDS, '0);
		send_block(64'h65736f6874206e49, 64'h202e72656e6f6f70, 0);
		send_block('1, '0, 1);

		// Counts above the cell count saturate; the upper data bits are dropped.
		wait_idle();
		write_reg(REG_ROUNDS, '1);
		send_block(rand_word(), rand_word(), 0);
		wait_idle();
		write_reg(REG_ROUNDS, WORD_W'(ROUNDS_LIMIT + 1));
		send_block(rand_word(), rand_word(), 0);
		wait_idle();
		write_reg(REG_ROUNDS, WORD_W'(1));
		send_block('0, '0, 0);
		send_block('1, '1, 0);

		// Writes beyond the register list must leave the key and count untouched.
		load_key('1, '1, '1, '1, WORD_W'(ROUNDS_RESET));
		for (logic [3:0] idx = 4'(REG_ROUNDS) + 4'd1; idx <= REG_LAST; idx++)
			write_reg(idx[2:0], '0);
		send_block('0, '0, 0);
		send_block(rand_word(), rand_word(), 2);

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 7))
				0: rounds_word = '0;
				1: rounds_word = WORD_W'(63);
				2: rounds_word = WORD_W'($urandom_range(ROUNDS_LIMIT + 1, 63));
				3: rounds_word = WORD_W'($urandom_range(1, ROUNDS_LIMIT - 1));
				default: rounds_word = WORD_W'(ROUNDS_LIMIT);
			endcase
			if ($urandom_range(0, 1) == 1)
				rounds_word[WORD_W-1:RND_W] = (WORD_W-RND_W)'(rand_word());
			load_key(pick_word(), pick_word(), pick_word(), pick_word(), rounds_word);
			if ($urandom_range(0, 3) == 0)
				write_reg(3'($urandom_range(REG_ROUNDS + 1, REG_LAST)), rand_word());
			mode = $urandom_range(0, 2);
			batch = $urandom_range(40, 160);
			for (int i = 0; i < batch && sent < RANDOM_WORDS; i++) begin
				send_block(pick_word(), pick_word(), pick_gap(mode));
				sent++;
			end
		end

		wait_idle();
		repeat (LATENCY + 8) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
